>>> rtl/bson_document_validator_top_defines.svh
// assertion macros used by the checker of the bson document validator
// no dependencies; included by bdv_checker.sv

`ifndef BSON_DOCUMENT_VALIDATOR_TOP_DEFINES_SVH
`define BSON_DOCUMENT_VALIDATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BDV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BDV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bdv_pkg.sv
// shared types and constants of the bson document validator
// no dependencies; used by the top level and its checker

package bdv_pkg;

	localparam int unsigned COUNT_BITS_DEF = 32;

	typedef enum logic [2:0] {
		FAIL_OK,
		FAIL_SHORT,
		FAIL_BAD_LENGTH,
		FAIL_NO_TERM,
		FAIL_BAD_NAME,
		FAIL_BAD_VALUE,
		FAIL_END_MISMATCH
	} fail_code_t;

	// element type codes
	localparam logic [7:0] TYPE_DOUBLE    = 8'h01;
	localparam logic [7:0] TYPE_STRING    = 8'h02;
	localparam logic [7:0] TYPE_DOCUMENT  = 8'h03;
	localparam logic [7:0] TYPE_ARRAY     = 8'h04;
	localparam logic [7:0] TYPE_BINARY    = 8'h05;
	localparam logic [7:0] TYPE_UNDEFINED = 8'h06;
	localparam logic [7:0] TYPE_OBJECT_ID = 8'h07;
	localparam logic [7:0] TYPE_BOOLEAN   = 8'h08;
	localparam logic [7:0] TYPE_DATETIME  = 8'h09;
	localparam logic [7:0] TYPE_NULL      = 8'h0A;
	localparam logic [7:0] TYPE_REGEX     = 8'h0B;
	localparam logic [7:0] TYPE_DB_POINTER = 8'h0C;
	localparam logic [7:0] TYPE_CODE      = 8'h0D;
	localparam logic [7:0] TYPE_SYMBOL    = 8'h0E;
	localparam logic [7:0] TYPE_CODE_SCOPE = 8'h0F;
	localparam logic [7:0] TYPE_INT32     = 8'h10;
	localparam logic [7:0] TYPE_TIMESTAMP = 8'h11;
	localparam logic [7:0] TYPE_INT64     = 8'h12;
	localparam logic [7:0] TYPE_DECIMAL128 = 8'h13;
	localparam logic [7:0] TYPE_MAX_KEY   = 8'h7F;
	localparam logic [7:0] TYPE_MIN_KEY   = 8'hFF;

	localparam logic [31:0] MIN_DOC_LENGTH = 32'd5;

endpackage

>>> rtl/bson_document_validator_top.sv
// bson document validator: walks one buffer a byte at a time and reports on the end byte
// depends on bdv_pkg
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_stall    | data_byte, end_of_buffer
//  out     | out_valid / out_stall  | doc_valid, fail_code, declared_length
//
// one byte per cycle while in_stall is low; a byte is held in the input register, and its
// walk step (counter, compare and length-field updates) runs between that register and the
// state and result registers: an end byte passes the input register, then the result registers.
// reset clears the walk state; after each end byte the state returns to its reset values.
// out_stall only holds back an end byte: other bytes keep flowing while a result waits.

module bson_document_validator_top #(
	parameter int unsigned COUNT_BITS = bdv_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_buffer,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               doc_valid,
	output logic [2:0]         fail_code,
	output logic signed [31:0] declared_length
);
	import bdv_pkg::*;

	localparam int unsigned CB = COUNT_BITS;
	localparam int unsigned W  = 34;
	localparam logic [CB-1:0] OFF_MAX = '1;
	localparam logic [32:0] CNT_LIMIT = 33'((64'd1 << CB) - 64'd1);

	typedef enum logic [2:0] {
		PH_LEN, PH_TYPE, PH_NAME, PH_PREFIX, PH_SKIP, PH_REGEX, PH_DONE, PH_HALT
	} phase_t;

	// input stage
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eob_s1;

	// walk state
	logic [CB-1:0] offset_q;
	logic [31:0]   doc_len_q;
	phase_t        phase_q;
	logic [7:0]    elem_type_q;
	logic [CB-1:0] value_end_q;
	logic [31:0]   len_acc_q;
	logic [1:0]    str_cnt_q;
	fail_code_t    first_fail_q;
	logic [7:0]    last_byte_q;

	// result
	logic        out_valid_q;
	logic        doc_valid_q;
	fail_code_t  fail_code_q;
	logic [31:0] decl_len_q;

	logic out_free, proceed, in_take;

	logic [CB-1:0] n_offset;
	logic [31:0]   n_doc_len;
	phase_t        n_phase;
	logic [7:0]    n_elem_type;
	logic [CB-1:0] n_value_end;
	logic [31:0]   n_len_acc;
	logic [1:0]    n_str_cnt;
	fail_code_t    n_first_fail;
	logic [7:0]    n_last_byte;
	fail_code_t    res_code;

	assign out_free = !out_valid_q || !out_stall;
	assign proceed  = valid_s1 && (!eob_s1 || out_free);
	assign in_stall = valid_s1 && !proceed;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		logic [CB-1:0] dl;
		logic [CB-1:0] r;
		logic          in_doc;
		logic          at_last;
		logic [W-1:0]  o_w;
		logic [W-1:0]  r_w;
		logic [W-1:0]  dl_w;
		logic          fail_req;
		fail_code_t    fail_sel;
		logic          ev_req;
		logic [W-1:0]  ev_vend;
		logic          ev_direct;
		logic [4:0]    fixed_sz;
		logic [31:0]   acc_new;
		logic [31:0]   lo;
		logic signed [5:0] adj;
		logic [W-1:0]  vend;
		logic [1:0]    cnt1;
		logic [CB:0]   size_w;
		logic          len_ok;

		dl        = doc_len_q[CB-1:0];
		in_doc    = offset_q < dl;
		at_last   = offset_q == (dl - CB'(1));
		r         = dl - offset_q - CB'(1);
		o_w       = W'(offset_q);
		r_w       = W'(r);
		dl_w      = W'(dl);
		fail_req  = 1'b0;
		fail_sel  = FAIL_OK;
		ev_req    = 1'b0;
		ev_vend   = '0;
		ev_direct = 1'b0;
		fixed_sz  = '0;
		acc_new   = len_acc_q | (32'(data_s1) << {str_cnt_q, 3'b000});
		lo        = '0;
		adj       = '0;
		vend      = '0;
		cnt1      = str_cnt_q + 2'd1;

		n_offset     = (offset_q != OFF_MAX) ? offset_q + CB'(1) : offset_q;
		n_doc_len    = doc_len_q;
		n_phase      = phase_q;
		n_elem_type  = elem_type_q;
		n_value_end  = value_end_q;
		n_len_acc    = len_acc_q;
		n_str_cnt    = str_cnt_q;
		n_first_fail = first_fail_q;
		n_last_byte  = last_byte_q;

		if (phase_q == PH_LEN) begin
			n_doc_len = doc_len_q | (32'(data_s1) << {offset_q[1:0], 3'b000});
			if (offset_q == CB'(3)) begin
				len_ok = !n_doc_len[31] && n_doc_len >= MIN_DOC_LENGTH
					&& {1'b0, n_doc_len} <= CNT_LIMIT;
				n_phase = len_ok ? PH_TYPE : PH_HALT;
			end
		end else if (in_doc) begin
			if (at_last) begin
				n_last_byte = data_s1;
			end
			case (phase_q)
				PH_TYPE: begin
					if (at_last) begin
						n_phase = PH_DONE;
					end else begin
						n_elem_type = data_s1;
						n_phase     = PH_NAME;
					end
				end
				PH_NAME: begin
					if (data_s1 == 8'h00) begin
						n_str_cnt = '0;
						n_len_acc = '0;
						if (r == '0) begin
							fail_req = 1'b1;
							fail_sel = FAIL_BAD_VALUE;
						end else begin
							case (elem_type_q)
								TYPE_DOUBLE, TYPE_DATETIME, TYPE_TIMESTAMP, TYPE_INT64:
									fixed_sz = 5'd8;
								TYPE_OBJECT_ID:  fixed_sz = 5'd12;
								TYPE_BOOLEAN:    fixed_sz = 5'd1;
								TYPE_INT32:      fixed_sz = 5'd4;
								TYPE_DECIMAL128: fixed_sz = 5'd16;
								default:         fixed_sz = '0;
							endcase
							case (elem_type_q)
								TYPE_UNDEFINED, TYPE_NULL, TYPE_MAX_KEY, TYPE_MIN_KEY:
									n_phase = PH_TYPE;
								TYPE_STRING, TYPE_DOCUMENT, TYPE_ARRAY, TYPE_DB_POINTER,
								TYPE_CODE, TYPE_SYMBOL, TYPE_CODE_SCOPE: begin
									if (r_w < W'(4)) begin
										fail_req = 1'b1;
										fail_sel = FAIL_BAD_VALUE;
									end else begin
										n_phase = PH_PREFIX;
									end
								end
								TYPE_BINARY: begin
									if (r_w < W'(5)) begin
										fail_req = 1'b1;
										fail_sel = FAIL_BAD_VALUE;
									end else begin
										n_phase = PH_PREFIX;
									end
								end
								TYPE_REGEX: n_phase = PH_REGEX;
								default: begin
									if (fixed_sz == '0) begin
										fail_req = 1'b1;
										fail_sel = FAIL_BAD_VALUE;
									end else if (W'(fixed_sz) > r_w) begin
										fail_req = 1'b1;
										fail_sel = FAIL_BAD_VALUE;
									end else begin
										ev_req  = 1'b1;
										ev_vend = o_w + W'(1) + W'(fixed_sz);
									end
								end
							endcase
						end
					end else if (at_last) begin
						fail_req = 1'b1;
						fail_sel = FAIL_BAD_NAME;
					end
				end
				PH_PREFIX: begin
					n_len_acc = acc_new;
					if (str_cnt_q == 2'd3) begin
						// value end measured from the current byte: start is offset - 3
						case (elem_type_q)
							TYPE_STRING, TYPE_CODE, TYPE_SYMBOL: begin
								lo = 32'd1;  adj = 6'sd1;
							end
							TYPE_DOCUMENT, TYPE_ARRAY: begin
								lo = 32'd5;  adj = -6'sd3;
							end
							TYPE_BINARY: begin
								lo = 32'd0;  adj = 6'sd2;
							end
							TYPE_DB_POINTER: begin
								lo = 32'd1;  adj = 6'sd13;
							end
							default: begin
								lo = 32'd14; adj = -6'sd3;
							end
						endcase
						vend = o_w + W'(acc_new) + {{(W-6){adj[5]}}, adj};
						if (acc_new[31] || acc_new < lo || vend > dl_w) begin
							fail_req = 1'b1;
							fail_sel = FAIL_BAD_VALUE;
						end else begin
							ev_req    = 1'b1;
							ev_vend   = vend;
							ev_direct = vend == (o_w + W'(1));
						end
					end else begin
						n_str_cnt = cnt1;
					end
				end
				PH_SKIP: begin
					if ((o_w + W'(1)) == W'(value_end_q)) begin
						n_phase = PH_TYPE;
					end
				end
				PH_REGEX: begin
					if (data_s1 == 8'h00) begin
						n_str_cnt = cnt1;
					end
					if (data_s1 == 8'h00 && cnt1 >= 2'd2) begin
						ev_req    = 1'b1;
						ev_vend   = o_w + W'(1);
						ev_direct = 1'b1;
					end else if (at_last) begin
						fail_req = 1'b1;
						fail_sel = FAIL_BAD_VALUE;
					end
				end
				default: ;
			endcase
		end

		// value that reaches the terminator position is an end mismatch
		if (ev_req) begin
			if (ev_vend == dl_w) begin
				fail_req = 1'b1;
				fail_sel = FAIL_END_MISMATCH;
			end else begin
				n_value_end = ev_vend[CB-1:0];
				n_phase     = ev_direct ? PH_TYPE : PH_SKIP;
			end
		end
		if (fail_req) begin
			n_phase = PH_HALT;
			if (first_fail_q == FAIL_OK) begin
				n_first_fail = fail_sel;
			end
		end

		size_w = {1'b0, offset_q} + (CB+1)'(1);
		len_ok = !n_doc_len[31] && n_doc_len >= MIN_DOC_LENGTH
			&& {1'b0, n_doc_len} <= CNT_LIMIT;
		if (size_w < (CB+1)'(5)) begin
			res_code = FAIL_SHORT;
		end else if (!len_ok || {1'b0, n_doc_len} > 33'(size_w)) begin
			res_code = FAIL_BAD_LENGTH;
		end else if (n_last_byte != 8'h00) begin
			res_code = FAIL_NO_TERM;
		end else if (n_first_fail != FAIL_OK) begin
			res_code = n_first_fail;
		end else if (n_phase != PH_DONE) begin
			res_code = FAIL_END_MISMATCH;
		end else begin
			res_code = FAIL_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			offset_q     <= '0;
			doc_len_q    <= '0;
			phase_q      <= PH_LEN;
			elem_type_q  <= '0;
			value_end_q  <= '0;
			len_acc_q    <= '0;
			str_cnt_q    <= '0;
			first_fail_q <= FAIL_OK;
			last_byte_q  <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (proceed) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= proceed && eob_s1;
			end
			if (proceed) begin
				if (eob_s1) begin
					offset_q     <= '0;
					doc_len_q    <= '0;
					phase_q      <= PH_LEN;
					elem_type_q  <= '0;
					value_end_q  <= '0;
					len_acc_q    <= '0;
					str_cnt_q    <= '0;
					first_fail_q <= FAIL_OK;
					last_byte_q  <= '0;
				end else begin
					offset_q     <= n_offset;
					doc_len_q    <= n_doc_len;
					phase_q      <= n_phase;
					elem_type_q  <= n_elem_type;
					value_end_q  <= n_value_end;
					len_acc_q    <= n_len_acc;
					str_cnt_q    <= n_str_cnt;
					first_fail_q <= n_first_fail;
					last_byte_q  <= n_last_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
		if (proceed && eob_s1 && out_free) begin
			doc_valid_q <= res_code == FAIL_OK;
			fail_code_q <= res_code;
			decl_len_q  <= n_doc_len;
		end
	end

	assign out_valid       = out_valid_q;
	assign doc_valid       = doc_valid_q;
	assign fail_code       = fail_code_q;
	assign declared_length = decl_len_q;

endmodule

>>> rtl/bdv_checker.sv
// port-level checks of the bson document validator, bound to its top level
// depends on bdv_pkg and bson_document_validator_top_defines.svh

`include "bson_document_validator_top_defines.svh"

module bdv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               doc_valid,
	input logic [2:0]         fail_code,
	input logic signed [31:0] declared_length
);
	import bdv_pkg::*;

	// a result waiting on the output is held unchanged
	`BDV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(doc_valid) && $stable(fail_code) && $stable(declared_length), "stalled result changed")

	// valid flag agrees with the code
	`BDV_ASSERT_NOW(a_valid_code, clk, arst_n, out_valid, doc_valid == (fail_code == FAIL_OK), "doc_valid disagrees with fail_code")

	// a clean document always carries a sane length
	`BDV_ASSERT_NOW(a_ok_length, clk, arst_n, out_valid && fail_code == FAIL_OK, declared_length >= 32'sd5, "valid document with length below five")

	// input only backs up behind a stalled result
	`BDV_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

endmodule

bind bson_document_validator_top bdv_checker u_bdv_checker (.*);
